FILE: rtl/yuv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_pkg: shared constants, types and helpers for the YUYV to RGB converter
// Holds the fixed-point color coefficients, product and sum widths, and the
// per-channel clamp and output range scaling.
// ----------------------------------------------------------------------------
package yuv_pkg;

    // Field widths
    localparam int PIX_W  = 8;                  // luma, chroma and channel bytes
    localparam int FRAC_W = 16;                 // fractional bits of coefficients
    localparam int COEF_W = 17;                 // unsigned coefficient width
    localparam int DIFF_W = PIX_W + 1;          // signed chroma difference
    localparam int FULL_W = COEF_W + 1 + DIFF_W; // full signed product width
    localparam int PROD_W = 25;                 // |coef * diff| < 2^24
    localparam int SUM_W  = 26;                 // Y*2^16 + term < 2^25
    localparam int SCL_W  = 16;                 // channel * scale factor

    // One pixel lane per luma byte of a macropixel
    localparam int LANES  = 2;

    // Coefficients, 16 fractional bits, rounded to nearest
    localparam logic [COEF_W-1:0] K_R  = 17'd89831;   // 1.370705
    localparam logic [COEF_W-1:0] K_GV = 17'd45744;   // 0.698001
    localparam logic [COEF_W-1:0] K_GU = 17'd22127;   // 0.337633
    localparam logic [COEF_W-1:0] K_B  = 17'd113538;  // 1.732446

    localparam logic [DIFF_W-1:0] CHROMA_OFFSET = 9'd128;
    localparam logic [DIFF_W-1:0] CHANNEL_MAX   = 9'd255;
    localparam logic [PIX_W-1:0]  SCALE_NUM     = 8'd220;
    localparam int                SCALE_SHIFT   = 8;

    // Chroma products shared by both pixels of a macropixel
    typedef struct packed {
        logic signed [PROD_W-1:0] r;    // K_R  * dv
        logic signed [PROD_W-1:0] gv;   // K_GV * dv
        logic signed [PROD_W-1:0] gu;   // K_GU * du
        logic signed [PROD_W-1:0] b;    // K_B  * du
    } t_chroma_prod;

    // One RGB pixel
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    // Truncate a fixed-point sum toward zero, clamp to 0..255, scale by 220/256
    function automatic logic [PIX_W-1:0] to_channel(input logic signed [SUM_W-1:0] sum);
        logic [DIFF_W-1:0] int_part;
        logic [PIX_W-1:0]  clamped;
        logic [SCL_W-1:0]  scaled;
        int_part = sum[FRAC_W+DIFF_W-1:FRAC_W];
        if (sum[SUM_W-1]) begin
            clamped = '0;
        end else if (int_part > CHANNEL_MAX) begin
            clamped = CHANNEL_MAX[PIX_W-1:0];
        end else begin
            clamped = int_part[PIX_W-1:0];
        end
        scaled = {{(SCL_W-PIX_W){1'b0}}, clamped} * {{(SCL_W-PIX_W){1'b0}}, SCALE_NUM};
        return scaled[SCALE_SHIFT+PIX_W-1:SCALE_SHIFT];
    endfunction

endpackage

FILE: rtl/yuv_chroma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_chroma: shared chroma product stage
// Removes the chroma offset and forms the four coefficient products once per
// macropixel; the products are registered along with the lumas and mark.
// ----------------------------------------------------------------------------
module yuv_chroma import yuv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [PIX_W-1:0]     i_first_luma,
    input  logic [PIX_W-1:0]     i_second_luma,
    input  logic [PIX_W-1:0]     i_blue_difference,
    input  logic [PIX_W-1:0]     i_red_difference,
    input  logic                 i_frame_end,
    output logic                 o_valid,
    output logic [PIX_W-1:0]     o_first_luma,
    output logic [PIX_W-1:0]     o_second_luma,
    output logic                 o_frame_end,
    output t_chroma_prod         o_prod
);

    logic signed [DIFF_W-1:0] du;
    logic signed [DIFF_W-1:0] dv;
    logic signed [FULL_W-1:0] full_r, full_gv, full_gu, full_b;
    t_chroma_prod             n_prod;
    t_chroma_prod             r_prod;
    logic                     r_valid;
    logic [PIX_W-1:0]         r_first_luma, r_second_luma;
    logic                     r_frame_end;

    // Signed chroma differences
    assign du = $signed({1'b0, i_blue_difference} - CHROMA_OFFSET);
    assign dv = $signed({1'b0, i_red_difference} - CHROMA_OFFSET);

    // Coefficient products; magnitudes fit in PROD_W signed bits
    assign full_r  = $signed({1'b0, K_R})  * dv;
    assign full_gv = $signed({1'b0, K_GV}) * dv;
    assign full_gu = $signed({1'b0, K_GU}) * du;
    assign full_b  = $signed({1'b0, K_B})  * du;

    always_comb begin
        n_prod.r  = $signed(full_r[PROD_W-1:0]);
        n_prod.gv = $signed(full_gv[PROD_W-1:0]);
        n_prod.gu = $signed(full_gu[PROD_W-1:0]);
        n_prod.b  = $signed(full_b[PROD_W-1:0]);
    end

    // Stage valid (control)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        r_prod        <= n_prod;
        r_first_luma  <= i_first_luma;
        r_second_luma <= i_second_luma;
        r_frame_end   <= i_frame_end;
    end

    assign o_valid       = r_valid;
    assign o_first_luma  = r_first_luma;
    assign o_second_luma = r_second_luma;
    assign o_frame_end   = r_frame_end;
    assign o_prod        = r_prod;

endmodule

FILE: rtl/yuv_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_lane: per-pixel color lane
// Adds the luma to the shared chroma products and reduces each channel to the
// clamped, range-scaled output byte. One lane per pixel of the macropixel.
// ----------------------------------------------------------------------------
module yuv_lane import yuv_pkg::*; (
    input  logic [PIX_W-1:0] i_luma,
    input  t_chroma_prod     i_prod,
    output t_rgb             o_pixel
);

    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

    // Luma in fixed point
    assign base = $signed({{(SUM_W-PIX_W-FRAC_W){1'b0}}, i_luma, {FRAC_W{1'b0}}});

    // Channel sums
    assign sum_r = base + SUM_W'(i_prod.r);
    assign sum_g = base - SUM_W'(i_prod.gv) - SUM_W'(i_prod.gu);
    assign sum_b = base + SUM_W'(i_prod.b);

    // Clamp and scale
    always_comb begin
        o_pixel.red   = to_channel(sum_r);
        o_pixel.green = to_channel(sum_g);
        o_pixel.blue  = to_channel(sum_b);
    end

endmodule

FILE: rtl/yuyv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter: YUYV 4:2:2 macropixel to two RGB888 pixels
// Shared chroma products feed two pixel lanes; the merge stage registers both
// pixels and the frame-end mark as one result.
//
//  Channel  | Handshake        | Payload
//  ---------+------------------+--------------------------------------------
//  input    | start / busy     | i_first_luma, i_blue_difference,
//           |                  | i_second_luma, i_red_difference,
//           |                  | i_frame_end_in
//  result   | o_valid strobe   | o_first_/o_second_ red, green, blue,
//           |                  | o_frame_end_out
//
// One macropixel is accepted every cycle; busy is never raised.
// After a transfer the result is registered first in the chroma multiplier
// stage, then, past the combinational lane adders, in the output register.
// Reset (synchronous, active low) clears the stage valid bits only.
// Results are held for exactly one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter import yuv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] i_first_luma,
    input  logic [PIX_W-1:0] i_blue_difference,
    input  logic [PIX_W-1:0] i_second_luma,
    input  logic [PIX_W-1:0] i_red_difference,
    input  logic             i_frame_end_in,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_first_red,
    output logic [PIX_W-1:0] o_first_green,
    output logic [PIX_W-1:0] o_first_blue,
    output logic [PIX_W-1:0] o_second_red,
    output logic [PIX_W-1:0] o_second_green,
    output logic [PIX_W-1:0] o_second_blue,
    output logic             o_frame_end_out
);

    logic             s1_valid;
    logic [PIX_W-1:0] s1_first_luma, s1_second_luma;
    logic             s1_frame_end;
    t_chroma_prod     s1_prod;
    logic [PIX_W-1:0] lane_luma [LANES];
    t_rgb             lane_pix  [LANES];
    logic             r_valid;
    t_rgb             r_first, r_second;
    logic             r_frame_end;

    // Fully pipelined, never stalls
    assign busy = 1'b0;

    // Shared chroma products
    yuv_chroma u_chroma (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (start & ~busy),
        .i_first_luma      (i_first_luma),
        .i_second_luma     (i_second_luma),
        .i_blue_difference (i_blue_difference),
        .i_red_difference  (i_red_difference),
        .i_frame_end       (i_frame_end_in),
        .o_valid           (s1_valid),
        .o_first_luma      (s1_first_luma),
        .o_second_luma     (s1_second_luma),
        .o_frame_end       (s1_frame_end),
        .o_prod            (s1_prod)
    );

    assign lane_luma[0] = s1_first_luma;
    assign lane_luma[1] = s1_second_luma;

    // Pixel lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        yuv_lane u_lane (
            .i_luma  (lane_luma[g]),
            .i_prod  (s1_prod),
            .o_pixel (lane_pix[g])
        );
    end

    // Merge: result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s1_valid;
        end
    end

    // Merge: result payload
    always_ff @(posedge i_clk) begin
        r_first     <= lane_pix[0];
        r_second    <= lane_pix[1];
        r_frame_end <= s1_frame_end;
    end

    assign o_valid         = r_valid;
    assign o_first_red     = r_first.red;
    assign o_first_green   = r_first.green;
    assign o_first_blue    = r_first.blue;
    assign o_second_red    = r_second.red;
    assign o_second_green  = r_second.green;
    assign o_second_blue   = r_second.blue;
    assign o_frame_end_out = r_frame_end;

    // Every result follows a matching transfer through both pipeline registers
    a_result_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without matching transfer");

    // Frame-end mark travels with its macropixel
    a_frame_end_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_end_out == $past(i_frame_end_in, 2)))
        else $error("frame-end mark misaligned");

    // Scaled channels stay within the compressed range
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_red <= 8'd219 && o_first_green <= 8'd219 &&
                     o_first_blue <= 8'd219 && o_second_red <= 8'd219 &&
                     o_second_green <= 8'd219 && o_second_blue <= 8'd219))
        else $error("channel above scaled range");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the YUYV to RGB converter
// A short table of macropixels (rails, neutral chroma, chroma corners) runs
// first, then about 1550 random macropixels in mixed styles. Each accepted
// transfer gets its two predicted RGB pixels queued, and each o_valid strobe
// is checked field by field against the oldest queued pair.
// ----------------------------------------------------------------------------
module tb import yuv_pkg::*;;

    // Fixed-point color coefficients, 16 fractional bits
    localparam longint COEF_RED   = 89831;
    localparam longint COEF_G_V   = 45744;
    localparam longint COEF_G_U   = 22127;
    localparam longint COEF_BLUE  = 113538;
    localparam int     FRAC_BITS  = 16;
    localparam int     RANDOM_ITEMS = 1550;
    localparam int     MAX_GAP    = 18;
    localparam int     DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel first;
        t_pixel second;
        logic   frame_end;
    } t_rgb_pair;

    // Directed row: one macropixel, plus grey levels where the chroma is neutral
    typedef struct packed {
        logic [PIX_W-1:0] y0;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] y1;
        logic [PIX_W-1:0] v;
        logic             fe;
        logic             typed;
        logic [PIX_W-1:0] grey0;
        logic [PIX_W-1:0] grey1;
    } t_stim_row;

    typedef enum int {
        PICK_ANY,
        PICK_CORNER,
        PICK_RAIL,
        PICK_NEUTRAL,
        PICK_LUMA_EDGE
    } t_byte_pick;

    localparam int DIRECTED_ROWS = 16;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{0,   128, 0,   128, 0, 1, 0,   0},    // black, neutral chroma
        '{255, 128, 255, 128, 1, 1, 219, 219},  // white, neutral chroma
        '{128, 128, 128, 128, 0, 1, 110, 110},  // mid grey
        '{0,   128, 255, 128, 1, 1, 0,   219},  // luma rails split across pixels
        '{16,  128, 235, 128, 0, 1, 13,  201},  // video-range black and white
        '{0,   0,   0,   0,   0, 0, 0,   0},    // red and blue sums negative
        '{255, 255, 255, 255, 1, 0, 0,   0},    // red and blue sums above range
        '{255, 0,   255, 0,   0, 0, 0,   0},
        '{0,   255, 0,   255, 1, 0, 0,   0},
        '{255, 0,   0,   255, 0, 0, 0,   0},
        '{0,   255, 255, 0,   1, 0, 0,   0},
        '{128, 127, 128, 129, 0, 0, 0,   0},    // chroma one step off neutral
        '{128, 129, 128, 127, 1, 0, 0,   0},
        '{1,   254, 254, 1,   0, 0, 0,   0},
        '{85,  170, 170, 85,  1, 0, 0,   0},    // alternating bit patterns
        '{170, 85,  85,  170, 0, 0, 0,   0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [PIX_W-1:0] i_first_luma;
    logic [PIX_W-1:0] i_blue_difference;
    logic [PIX_W-1:0] i_second_luma;
    logic [PIX_W-1:0] i_red_difference;
    logic             i_frame_end_in;
    logic             o_valid;
    logic [PIX_W-1:0] o_first_red;
    logic [PIX_W-1:0] o_first_green;
    logic [PIX_W-1:0] o_first_blue;
    logic [PIX_W-1:0] o_second_red;
    logic [PIX_W-1:0] o_second_green;
    logic [PIX_W-1:0] o_second_blue;
    logic             o_frame_end_out;

    t_rgb_pair expected_rgb_q [$];
    int        mismatch_count;

    yuyv_to_rgb_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_luma     (i_first_luma),
        .i_blue_difference(i_blue_difference),
        .i_second_luma    (i_second_luma),
        .i_red_difference (i_red_difference),
        .i_frame_end_in   (i_frame_end_in),
        .o_valid          (o_valid),
        .o_first_red      (o_first_red),
        .o_first_green    (o_first_green),
        .o_first_blue     (o_first_blue),
        .o_second_red     (o_second_red),
        .o_second_green   (o_second_green),
        .o_second_blue    (o_second_blue),
        .o_frame_end_out  (o_frame_end_out)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Truncate toward zero, clamp to 0..255, compress by 220/256
    function automatic logic [PIX_W-1:0] scale_channel(input longint sum);
        longint whole;
        if (sum < 0) begin
            whole = 0;
        end else begin
            whole = sum >>> FRAC_BITS;
        end
        if (whole > 255) begin
            whole = 255;
        end
        whole = (whole * 220) >>> 8;
        return whole[PIX_W-1:0];
    endfunction

    function automatic t_pixel convert_pixel(input logic [PIX_W-1:0] luma,
                                             input longint du, input longint dv);
        t_pixel px;
        longint base;
        base     = longint'(luma) <<< FRAC_BITS;
        px.red   = scale_channel(base + COEF_RED * dv);
        px.green = scale_channel(base - COEF_G_V * dv - COEF_G_U * du);
        px.blue  = scale_channel(base + COEF_BLUE * du);
        return px;
    endfunction

    function automatic t_rgb_pair predict_rgb_pair(input logic [PIX_W-1:0] y0,
                                                   input logic [PIX_W-1:0] u,
                                                   input logic [PIX_W-1:0] y1,
                                                   input logic [PIX_W-1:0] v,
                                                   input logic fe);
        t_rgb_pair pair;
        longint    du;
        longint    dv;
        du             = longint'(u) - 128;
        dv             = longint'(v) - 128;
        pair.first     = convert_pixel(y0, du, dv);
        pair.second    = convert_pixel(y1, du, dv);
        pair.frame_end = fe;
        return pair;
    endfunction

    // Random byte in one of several styles
    function automatic logic [PIX_W-1:0] pick_byte(input t_byte_pick how);
        case (how)
            PICK_CORNER: begin
                case ($urandom_range(0, 6))
                    0:       return 8'd0;
                    1:       return 8'd1;
                    2:       return 8'd127;
                    3:       return 8'd128;
                    4:       return 8'd129;
                    5:       return 8'd254;
                    default: return 8'd255;
                endcase
            end
            PICK_RAIL:      return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            PICK_NEUTRAL:   return 8'($urandom_range(125, 131));
            PICK_LUMA_EDGE: begin
                if ($urandom_range(0, 1) != 0) begin
                    return 8'($urandom_range(0, 20));
                end else begin
                    return 8'($urandom_range(235, 255));
                end
            end
            default:        return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Hold start low for the requested idle gap, with junk on the payload
    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start             <= 1'b0;
            i_first_luma      <= 8'($urandom);
            i_blue_difference <= 8'($urandom);
            i_second_luma     <= 8'($urandom);
            i_red_difference  <= 8'($urandom);
            i_frame_end_in    <= 1'($urandom);
        end
    endtask

    // Present one macropixel and queue its expected pair once the transfer happens
    task automatic send_macropixel(input logic [PIX_W-1:0] y0, input logic [PIX_W-1:0] u,
                                   input logic [PIX_W-1:0] y1, input logic [PIX_W-1:0] v,
                                   input logic fe, input logic typed,
                                   input t_rgb_pair typed_pair);
        @(negedge i_clk);
        start             <= 1'b1;
        i_first_luma      <= y0;
        i_blue_difference <= u;
        i_second_luma     <= y1;
        i_red_difference  <= v;
        i_frame_end_in    <= fe;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (typed) begin
            expected_rgb_q.push_back(typed_pair);
        end else begin
            expected_rgb_q.push_back(predict_rgb_pair(y0, u, y1, v, fe));
        end
    endtask

    task automatic wait_all_results();
        while (expected_rgb_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic compare_field(input string what, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_rgb_pair want;
        if (i_rst_n && o_valid) begin
            if (expected_rgb_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual r0=%0d g0=%0d b0=%0d",
                         $time, o_first_red, o_first_green, o_first_blue);
                mismatch_count++;
            end else begin
                want = expected_rgb_q.pop_front();
                compare_field("first_red",     want.first.red,    o_first_red);
                compare_field("first_green",   want.first.green,  o_first_green);
                compare_field("first_blue",    want.first.blue,   o_first_blue);
                compare_field("second_red",    want.second.red,   o_second_red);
                compare_field("second_green",  want.second.green, o_second_green);
                compare_field("second_blue",   want.second.blue,  o_second_blue);
                compare_field("frame_end_out", 8'(want.frame_end), 8'(o_frame_end_out));
            end
        end
    end

    // Stimulus: reset, directed table, random traffic, drain
    initial begin
        t_stim_row        row;
        t_rgb_pair        typed_pair;
        logic [PIX_W-1:0] y0;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] y1;
        logic [PIX_W-1:0] v;
        logic             fe;
        int               style;
        int               frame_left;
        bit               burst;

        mismatch_count    = 0;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_first_luma      = '0;
        i_blue_difference = '0;
        i_second_luma     = '0;
        i_red_difference  = '0;
        i_frame_end_in    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            typed_pair.first     = '{row.grey0, row.grey0, row.grey0};
            typed_pair.second    = '{row.grey1, row.grey1, row.grey1};
            typed_pair.frame_end = row.fe;
            idle_for((i < 8) ? 0 : $urandom_range(0, MAX_GAP));
            send_macropixel(row.y0, row.u, row.y1, row.v, row.fe, row.typed, typed_pair);
        end
        idle_for(1);
        wait_all_results();

        // Random traffic, in frames of random length
        frame_left = $urandom_range(0, 30);
        burst      = 1'b0;
        typed_pair = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                // let the pipe run dry before carrying on
                idle_for(1);
                wait_all_results();
            end
            style = $urandom_range(0, 9);
            case (style)
                5, 6: begin
                    y0 = pick_byte(PICK_CORNER);
                    u  = pick_byte(PICK_CORNER);
                    y1 = pick_byte(PICK_CORNER);
                    v  = pick_byte(PICK_CORNER);
                end
                7: begin
                    y0 = pick_byte(PICK_ANY);
                    u  = pick_byte(PICK_NEUTRAL);
                    y1 = pick_byte(PICK_ANY);
                    v  = pick_byte(PICK_NEUTRAL);
                end
                8: begin
                    y0 = pick_byte(PICK_LUMA_EDGE);
                    u  = pick_byte(PICK_ANY);
                    y1 = pick_byte(PICK_LUMA_EDGE);
                    v  = pick_byte(PICK_ANY);
                end
                9: begin
                    y0 = pick_byte(PICK_RAIL);
                    u  = pick_byte(PICK_RAIL);
                    y1 = pick_byte(PICK_RAIL);
                    v  = pick_byte(PICK_RAIL);
                end
                default: begin
                    y0 = pick_byte(PICK_ANY);
                    u  = pick_byte(PICK_ANY);
                    y1 = pick_byte(PICK_ANY);
                    v  = pick_byte(PICK_ANY);
                end
            endcase
            if (frame_left == 0) begin
                fe         = 1'b1;
                frame_left = $urandom_range(0, 30);
            end else begin
                fe         = 1'b0;
                frame_left--;
            end
            idle_for(burst ? 0 : $urandom_range(0, MAX_GAP));
            send_macropixel(y0, u, y1, v, fe, 1'b0, typed_pair);
        end
        idle_for(1);

        // Drain and report
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rgb_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
